/* src/fmr_pkg.sv */
// fmr_pkg: shared types and constants of the framed message receiver
`timescale 1ns / 1ps

package fmr_pkg;

  // frame geometry
  localparam int MAX_FRAME_LEN = 64;
  localparam int HEADER_BYTES  = 4;
  localparam int FRAMING_BYTES = HEADER_BYTES + 1;
  localparam int STORE_DEPTH   = MAX_FRAME_LEN - FRAMING_BYTES;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);
  localparam int POS_W         = $clog2(MAX_FRAME_LEN + 1);
  localparam int LEN_W         = 9;

  localparam logic [7:0]  SYNC_BYTE     = 8'hAA;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // request function codes
  typedef enum logic [1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_READ    = 2'd3
  } func_e;

  // result event codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_FULL     = 3'd2,
    EV_SYNC     = 3'd3,
    EV_LENGTH   = 3'd4,
    EV_CHECKSUM = 3'd5,
    EV_COMPLETE = 3'd6,
    EV_TIMEOUT  = 3'd7
  } event_e;

  // input request
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic [5:0] read_index;
  } fmr_req_t;

  // output result
  typedef struct packed {
    logic [2:0] event_res;
    logic       frame_ready;
    logic [7:0] destination;
    logic [5:0] payload_length;
    logic [7:0] read_data;
  } fmr_res_t;

  // status from the frame controller after one request
  typedef struct packed {
    event_e     ev;
    logic       frame_ready;
    logic [7:0] destination;
    logic [5:0] payload_length;
  } fmr_stat_t;

  // payload store write port
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } fmr_wr_t;

endpackage

/* src/fmr_frame_ctrl.sv */
// fmr_frame_ctrl: frame parse state, checksum, idle timer and store writes
`timescale 1ns / 1ps

module fmr_frame_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  fmr_pkg::fmr_req_t req_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  output fmr_pkg::fmr_stat_t stat_o,
  output fmr_pkg::fmr_wr_t wr_o
);
  import fmr_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] flen_q, flen_d;
  logic [7:0]       pcount_q, pcount_d;
  logic [7:0]       dest_q, dest_d;
  logic [7:0]       sum_q, sum_d;
  logic             held_q, held_d;
  logic             armed_q, armed_d;
  logic [15:0]      idle_q, idle_d;
  logic [15:0]      timeout_q;

  logic [LEN_W-1:0] flen_w;
  logic [LEN_W-1:0] pay_end;
  logic [POS_W-1:0] pos_n;
  logic [POS_W-1:0] flen_n;
  logic [POS_W-1:0] slot;
  logic [7:0]       sum_n;
  logic             wipe;
  event_e           ev;

  // state update for one request
  always_comb begin
    pos_d    = pos_q;
    flen_d   = flen_q;
    pcount_d = pcount_q;
    dest_d   = dest_q;
    sum_d    = sum_q;
    held_d   = held_q;
    armed_d  = armed_q;
    idle_d   = idle_q;
    wipe     = 1'b0;
    ev       = EV_NONE;
    wr_o     = '0;
    flen_w   = LEN_W'({1'b0, req_i.data_byte}) + LEN_W'(FRAMING_BYTES);
    pay_end  = LEN_W'(HEADER_BYTES) + LEN_W'(pcount_q);
    slot     = pos_q - POS_W'(HEADER_BYTES);
    sum_n    = sum_q;
    pos_n    = pos_q + POS_W'(1);
    flen_n   = flen_q;

    if (fire_i) begin
      unique case (func_e'(req_i.func))
        FUNC_BYTE: begin
          if (held_q) begin
            ev = EV_FULL;
          end else begin
            armed_d = 1'b1;
            idle_d  = '0;
            if (pos_q <= POS_W'(1) && req_i.data_byte != SYNC_BYTE) begin
              wipe = 1'b1;
              ev   = EV_SYNC;
            end else if (pos_q == POS_W'(2) && flen_w > LEN_W'(MAX_FRAME_LEN)) begin
              // oversize length: keep the length byte, drop the frame
              pcount_d = req_i.data_byte;
              wipe     = 1'b1;
              ev       = EV_LENGTH;
            end else begin
              if (pos_q == POS_W'(2)) begin
                pcount_d = req_i.data_byte;
                flen_n   = flen_w[POS_W-1:0];
                flen_d   = flen_n;
              end else if (pos_q == POS_W'(3)) begin
                dest_d = req_i.data_byte;
              end else if (pos_q >= POS_W'(HEADER_BYTES)
                           && LEN_W'(pos_q) < pay_end) begin
                // payload byte: store and accumulate
                if (slot < POS_W'(STORE_DEPTH)) begin
                  wr_o.we   = 1'b1;
                  wr_o.addr = slot[STORE_AW-1:0];
                  wr_o.data = req_i.data_byte;
                end
                sum_n = sum_q + req_i.data_byte;
                sum_d = sum_n;
              end
              pos_d = pos_n;
              // end of frame: check the inverted sum
              if (flen_n != '0 && pos_n >= flen_n) begin
                if (~sum_n == req_i.data_byte) begin
                  held_d = 1'b1;
                  ev     = EV_COMPLETE;
                end else begin
                  wipe = 1'b1;
                  ev   = EV_CHECKSUM;
                end
              end else begin
                ev = EV_STORED;
              end
            end
          end
        end
        FUNC_TICK: begin
          if (armed_q) begin
            if (idle_q >= timeout_q) begin
              wipe = 1'b1;
              ev   = EV_TIMEOUT;
            end else begin
              idle_d = idle_q + 16'd1;
            end
          end
        end
        FUNC_RELEASE: begin
          wipe = 1'b1;
        end
        FUNC_READ: begin
        end
        default: begin
        end
      endcase
    end

    // clear of the partial or held frame
    if (wipe) begin
      pos_d   = '0;
      flen_d  = '0;
      sum_d   = '0;
      held_d  = 1'b0;
      armed_d = 1'b0;
      idle_d  = '0;
    end

    stat_o.ev             = ev;
    stat_o.frame_ready    = held_d;
    stat_o.destination    = dest_d;
    stat_o.payload_length = pcount_d[5:0];
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      flen_q    <= '0;
      pcount_q  <= '0;
      dest_q    <= '0;
      sum_q     <= '0;
      held_q    <= 1'b0;
      armed_q   <= 1'b0;
      idle_q    <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      pos_q    <= pos_d;
      flen_q   <= flen_d;
      pcount_q <= pcount_d;
      dest_q   <= dest_d;
      sum_q    <= sum_d;
      held_q   <= held_d;
      armed_q  <= armed_d;
      idle_q   <= idle_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

endmodule

/* src/framed_message_receiver_top.sv */
// framed_message_receiver_top: request channel, payload store and result pipeline
`timescale 1ns / 1ps
//
// Usage
// - in channel: one request per accepted beat (func, data_byte, read_index).
//   func selects receive byte, millisecond tick, release of a held frame,
//   or read of one stored payload byte.
// - out channel: exactly one result per request, in request order
//   (event, frame_ready, destination, payload_length, read_data).
// - cfg: cfg_we_i writes timeout_ms from cfg_wdata_i; write only while idle.
// Pipeline: the accepting edge registers the frame controller update and the
//   store read, and the result register that drives the outputs loads from
//   the middle stage when that register is empty or out is not stalled.
// Throughput: one request per cycle while in_stall_o is low; the controller
//   update is combinational and the payload store has one write/one read port.
// Reset: frame state clears, timeout_ms returns to 1000; store contents are
//   undefined until written and are not cleared.
// Stall: a result waits in the output register and one more in the middle
//   stage; in_stall_o rises only when both are occupied and out is stalled.
//

module framed_message_receiver_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fmr_pkg::fmr_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fmr_pkg::fmr_res_t out_res_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);
  import fmr_pkg::*;

  logic      fire;
  logic      out_ready;
  logic      rd_en;
  fmr_stat_t stat;
  fmr_wr_t   wr;

  logic      s1_valid_q;
  fmr_stat_t s1_stat_q;
  logic      s1_rd_q;
  logic [7:0] rd_data_q;
  logic      out_valid_q;
  fmr_res_t  out_res_q;

  logic [7:0] store_mem [STORE_DEPTH];

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign fire       = in_valid_i && !in_stall_o;
  assign rd_en      = (in_req_i.func == FUNC_READ)
                      && (in_req_i.read_index < 6'(STORE_DEPTH));

  fmr_frame_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat),
    .wr_o        (wr)
  );

  // payload store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr.we) begin
      store_mem[wr.addr] <= wr.data;
    end
    if (fire && rd_en) begin
      rd_data_q <= store_mem[in_req_i.read_index[STORE_AW-1:0]];
    end
  end

  // middle stage payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_stat_q <= stat;
      s1_rd_q   <= rd_en;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_res_q.event_res      <= s1_stat_q.ev;
      out_res_q.frame_ready    <= s1_stat_q.frame_ready;
      out_res_q.destination    <= s1_stat_q.destination;
      out_res_q.payload_length <= s1_stat_q.payload_length;
      out_res_q.read_data      <= s1_rd_q ? rd_data_q : 8'd0;
    end
  end

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= fire || (s1_valid_q && !out_ready);
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

/* verif/fmr_result_check.sv */
// fmr_result_check: predicts and checks every result of the framed message receiver
`timescale 1ns / 1ps

module fmr_result_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  fmr_pkg::fmr_req_t              in_req_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  fmr_pkg::fmr_res_t              out_res_i,
  input  logic                           cfg_we_i,
  input  logic [15:0]                    cfg_wdata_i,
  output int                             mismatch_count_o,
  output int                             pending_o,
  output logic [fmr_pkg::STORE_DEPTH-1:0] stored_mask_o
);

  import fmr_pkg::*;

  // shadow copy of the receiver state
  logic [15:0] timeout_ms_q;
  logic [6:0]  rx_pos;
  logic [8:0]  rx_frame_len;
  logic [7:0]  rx_count;
  logic [7:0]  rx_dest;
  logic [7:0]  rx_sum;
  logic        rx_held;
  logic        rx_armed;
  logic [15:0] rx_idle;
  logic [7:0]  payload_mem [STORE_DEPTH];

  fmr_res_t    expected_results [$];
  int          results_seen;

  // one line per mismatch, counted for the verdict
  task automatic report_mismatch(string msg);
    $display("ERROR at %0t, result %0d: %s", $time, results_seen, msg);
    mismatch_count_o++;
  endtask

  // drop a partial or held frame; destination, count and store survive
  function automatic void clear_frame();
    rx_pos       = '0;
    rx_frame_len = '0;
    rx_sum       = '0;
    rx_held      = 1'b0;
    rx_armed     = 1'b0;
    rx_idle      = '0;
  endfunction

  // advance the shadow state by one request and build its result
  function automatic fmr_res_t predict_result(fmr_req_t req);
    fmr_res_t   res;
    event_e     ev;
    logic [7:0] b;
    int         slot;
    res = '0;
    ev  = EV_NONE;
    b   = req.data_byte;
    case (req.func)
      FUNC_BYTE: begin
        if (rx_held) begin
          // held frame refuses bytes, idle time keeps running
          ev = EV_FULL;
        end else begin
          rx_armed = 1'b1;
          rx_idle  = '0;
          if (rx_pos <= 7'd1 && b != SYNC_BYTE) begin
            clear_frame();
            ev = EV_SYNC;
          end else if (rx_pos == 7'd2 && int'(b) + FRAMING_BYTES > MAX_FRAME_LEN) begin
            rx_count = b;
            clear_frame();
            ev = EV_LENGTH;
          end else begin
            if (rx_pos == 7'd2) begin
              rx_count     = b;
              rx_frame_len = 9'(int'(b) + FRAMING_BYTES);
            end else if (rx_pos == 7'd3) begin
              rx_dest = b;
            end else if (rx_pos >= HEADER_BYTES &&
                         int'(rx_pos) < HEADER_BYTES + int'(rx_count)) begin
              slot = int'(rx_pos) - HEADER_BYTES;
              if (slot < STORE_DEPTH) begin
                payload_mem[slot]   = b;
                stored_mask_o[slot] = 1'b1;
              end
              rx_sum = rx_sum + b;
            end
            rx_pos = rx_pos + 7'd1;
            ev     = EV_STORED;
            // last byte of the frame carries the inverted sum
            if (rx_frame_len != '0 && rx_pos >= rx_frame_len) begin
              if ((rx_sum ^ 8'hFF) == b) begin
                rx_held = 1'b1;
                ev      = EV_COMPLETE;
              end else begin
                clear_frame();
                ev = EV_CHECKSUM;
              end
            end
          end
        end
      end
      FUNC_TICK: begin
        if (rx_armed) begin
          if (rx_idle >= timeout_ms_q) begin
            clear_frame();
            ev = EV_TIMEOUT;
          end else begin
            rx_idle = rx_idle + 16'd1;
          end
        end
      end
      FUNC_RELEASE: clear_frame();
      default: begin
        if (req.read_index < STORE_DEPTH) res.read_data = payload_mem[req.read_index];
      end
    endcase
    res.event_res      = ev;
    res.frame_ready    = rx_held;
    res.destination    = rx_dest;
    res.payload_length = rx_count[5:0];
    return res;
  endfunction

  // watch config, results and requests at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    fmr_res_t want;
    if (!rst_ni) begin
      timeout_ms_q = TIMEOUT_RESET;
      clear_frame();
      rx_count         = '0;
      rx_dest          = '0;
      stored_mask_o    = '0;
      mismatch_count_o = 0;
      results_seen     = 0;
      expected_results.delete();
      pending_o        = 0;
    end else begin
      if (cfg_we_i) timeout_ms_q = cfg_wdata_i;

      // compare an accepted result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = expected_results.pop_front();
          if (out_res_i.event_res !== want.event_res)
            report_mismatch($sformatf("event_res %0d, expected %0d",
                                      out_res_i.event_res, want.event_res));
          if (out_res_i.frame_ready !== want.frame_ready)
            report_mismatch($sformatf("frame_ready %0d, expected %0d",
                                      out_res_i.frame_ready, want.frame_ready));
          if (out_res_i.destination !== want.destination)
            report_mismatch($sformatf("destination %0h, expected %0h",
                                      out_res_i.destination, want.destination));
          if (out_res_i.payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length %0d, expected %0d",
                                      out_res_i.payload_length, want.payload_length));
          if (out_res_i.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %0h, expected %0h",
                                      out_res_i.read_data, want.read_data));
        end
      end

      // predict an accepted request
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_result(in_req_i));
      pending_o = expected_results.size();
    end
  end

endmodule

/* verif/testbench.sv */
// testbench: request stimulus and verdict for the framed message receiver
`timescale 1ns / 1ps

module testbench;

  import fmr_pkg::*;

  localparam int RANDOM_ITEMS = 400;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  fmr_req_t               in_req;
  logic                   out_valid;
  logic                   out_stall;
  fmr_res_t               out_res;
  logic                   cfg_we;
  logic [15:0]            cfg_wdata;
  int                     mismatches;
  int                     pending;
  logic [STORE_DEPTH-1:0] stored_mask;

  int                     items_sent;
  logic [15:0]            timeout_now;
  bit                     gaps_on;

  framed_message_receiver_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  fmr_result_check result_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_res_i        (out_res),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .stored_mask_o    (stored_mask)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // payload length: mostly short, sometimes anything up to the largest
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return STORE_DEPTH;
    if (r < 15) return $urandom_range(0, STORE_DEPTH);
    return $urandom_range(0, 6);
  endfunction

  // read position: a stored entry, or an index past the end of the store
  function automatic logic [5:0] pick_read_index();
    int start;
    if ($urandom_range(0, 7) == 0) return 6'($urandom_range(STORE_DEPTH, 63));
    start = $urandom_range(0, STORE_DEPTH - 1);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (stored_mask[(start + i) % STORE_DEPTH]) return 6'((start + i) % STORE_DEPTH);
    end
    return 6'($urandom_range(STORE_DEPTH, 63));
  endfunction

  // receiver stall pattern
  initial begin
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = gaps_on ? pick_gap() : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // one request; entered and left at a falling edge
  task automatic send_req(func_e f, logic [7:0] b, logic [5:0] idx);
    int n;
    n = gaps_on ? pick_gap() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_req   <= '{func: f, data_byte: b, read_index: idx};
    in_valid <= 1'b1;
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_req(FUNC_BYTE, b, 6'($urandom));
  endtask

  // full frame with random payload, optionally a bad sum or cut short
  task automatic send_frame(int len, logic [7:0] dest_b, bit bad_sum, int cut);
    logic [7:0] frame_q [$];
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    frame_q.push_back(SYNC_BYTE);
    frame_q.push_back(SYNC_BYTE);
    frame_q.push_back(8'(len));
    frame_q.push_back(dest_b);
    repeat (len) begin
      b = 8'($urandom);
      frame_q.push_back(b);
      sum = sum + b;
    end
    b = sum ^ 8'hFF;
    if (bad_sum) b = b ^ 8'($urandom_range(1, 255));
    frame_q.push_back(b);
    for (int i = 0; i < frame_q.size() && (cut == 0 || i < cut); i++) send_byte(frame_q[i]);
  endtask

  // clear the frame by idle ticks when the timeout is short, else release
  task automatic expire_frame();
    if (timeout_now <= 16'd12) begin
      repeat (int'(timeout_now) + 1) send_req(FUNC_TICK, 8'($urandom), 6'($urandom));
    end else begin
      send_req(FUNC_RELEASE, 8'($urandom), 6'($urandom));
    end
  endtask

  // hold requests until every result is back, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we      <= 1'b0;
    timeout_now = v;
  endtask

  // stimulus and verdict
  initial begin
    logic [15:0] phase_timeouts [6];
    int          base;
    int          pick;
    int          len;
    logic [7:0]  b;
    func_e       f;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req      = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    items_sent  = 0;
    timeout_now = TIMEOUT_RESET;
    gaps_on     = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle block: tick and release do nothing, read past the store
    send_req(FUNC_TICK, 8'hFF, 6'h3F);
    send_req(FUNC_RELEASE, 8'h00, 6'h00);
    send_req(FUNC_READ, 8'hFF, 6'd63);

    // empty frame held, then a refused byte and a tick while held
    send_frame(0, 8'hFF, 1'b0, 0);
    send_byte(8'h00);
    send_req(FUNC_TICK, 8'h00, 6'h00);
    send_req(FUNC_RELEASE, 8'hFF, 6'h3F);

    // sync errors on first and second byte
    send_byte(8'h00);
    send_byte(SYNC_BYTE);
    send_byte(8'h55);

    // shortest oversize length
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'd60);

    // two byte frame with extreme payload values, read back
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(8'd2);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_req(FUNC_READ, 8'h00, 6'd0);
    send_req(FUNC_READ, 8'h00, 6'd1);
    send_req(FUNC_RELEASE, 8'h00, 6'h00);

    // bad checksum
    send_frame(0, 8'h07, 1'b1, 0);

    // zero timeout: first tick clears
    drain_results();
    write_timeout(16'd0);
    send_byte(SYNC_BYTE);
    send_req(FUNC_TICK, 8'h00, 6'h00);

    // timeout of one: second tick clears
    drain_results();
    write_timeout(16'd1);
    send_byte(SYNC_BYTE);
    send_req(FUNC_TICK, 8'h00, 6'h00);
    send_req(FUNC_TICK, 8'h00, 6'h00);

    // random phases, one timeout setting each
    phase_timeouts = '{16'd3, 16'd0, 16'd65535, 16'd1, 16'd1000, 16'd6};
    base = items_sent;
    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_timeout(phase_timeouts[p]);
      while (items_sent < base + (p + 1) * RANDOM_ITEMS / 6) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        pick    = $urandom_range(0, 99);
        if (pick < 50) begin
          // good frame, some traffic while held, then release or time out
          if ($urandom_range(0, 2) == 0) send_req(FUNC_RELEASE, 8'($urandom), 6'($urandom));
          send_frame(pick_len(), 8'($urandom), 1'b0, 0);
          repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 2))
              0:       send_req(FUNC_READ, 8'($urandom), pick_read_index());
              1:       send_byte(8'($urandom));
              default: send_req(FUNC_TICK, 8'($urandom), 6'($urandom));
            endcase
          end
          if ($urandom_range(0, 4) != 0) begin
            send_req(FUNC_RELEASE, 8'($urandom), 6'($urandom));
          end else begin
            expire_frame();
          end
        end else if (pick < 60) begin
          send_frame(pick_len(), 8'($urandom), 1'b1, 0);
        end else if (pick < 67) begin
          // oversize length
          send_byte(SYNC_BYTE);
          send_byte(SYNC_BYTE);
          send_byte(8'($urandom_range(60, 255)));
        end else if (pick < 74) begin
          // broken sync
          if ($urandom_range(0, 1) == 1) send_byte(SYNC_BYTE);
          b = 8'($urandom);
          if (b == SYNC_BYTE) b = 8'h55;
          send_byte(b);
        end else if (pick < 84) begin
          // truncated frame, then cleared by timeout or release
          len = pick_len();
          send_frame(len, 8'($urandom), 1'b0, $urandom_range(1, len + 4));
          expire_frame();
        end else begin
          // noise
          repeat ($urandom_range(1, 4)) begin
            f = func_e'($urandom_range(0, 3));
            send_req(f, 8'($urandom), (f == FUNC_READ) ? pick_read_index() : 6'($urandom));
          end
        end
      end
    end

    drain_results();
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
